@@ src/dmxlbp_pkg.sv @@
package dmxlbp_pkg;

  localparam int MAX_CHANNELS_DEF = 512;

  // input action codes
  localparam logic [1:0] ACT_SET  = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_OFF  = 2'd2;

  // config register indexes
  localparam logic CFG_CHANNEL_COUNT = 1'b0;
  localparam logic CFG_DEVICE_READY  = 1'b1;
  localparam int   CFG_DW            = 10;

  // block format
  localparam logic [2:0] OP_FIRST     = 3'd4;
  localparam logic [2:0] OP_NEXT      = 3'd2;
  localparam logic [7:0] FIRST_DATA1  = 8'd1;
  localparam int         FIRST_LEVELS = 6;
  localparam int         BLOCK_LEVELS = 7;

  // level scaling: floor(v*255/25600) = floor(floor(v*255/256) / 100)
  localparam logic [14:0] PCT_FULL  = 15'd25600;
  localparam logic [7:0]  LEVEL_MAX = 8'd255;
  localparam logic [15:0] RECIP_100 = 16'd41944;  // ceil(2^22 / 100)
  localparam int          RECIP_SH  = 22;

  localparam int CMDQ_AW = 1;  // two-entry command queue

  typedef enum logic [1:0] {
    CMD_SET,
    CMD_TICK,
    CMD_OFF
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [8:0]  chan;
    logic [14:0] pct;   // already clamped to 0..25600
  } cmd_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_MUL,
    BK_SCALE,
    BK_RD,
    BK_FIN,
    BK_EMIT
  } back_state_t;

endpackage

@@ src/dmxlbp_ram.sv @@
module dmxlbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/dmxlbp_front.sv @@
module dmxlbp_front (
  input  logic              in_push,
  output logic              in_full,
  input  logic [1:0]        in_action,
  input  logic [8:0]        in_channel_index,
  input  logic signed [15:0] in_percent_value,
  input  logic              back_busy,
  input  logic              q_full,
  output logic              q_wr,
  output dmxlbp_pkg::cmd_t  q_wdata
);

  logic known;

  assign in_full = q_full | back_busy;

  always_comb begin
    q_wdata.chan = in_channel_index;
    // clamp to 0..100 percent
    if (in_percent_value[15]) begin
      q_wdata.pct = '0;
    end else if (in_percent_value[14:0] > dmxlbp_pkg::PCT_FULL) begin
      q_wdata.pct = dmxlbp_pkg::PCT_FULL;
    end else begin
      q_wdata.pct = in_percent_value[14:0];
    end
    known = 1'b1;
    unique case (in_action)
      dmxlbp_pkg::ACT_SET:  q_wdata.kind = dmxlbp_pkg::CMD_SET;
      dmxlbp_pkg::ACT_TICK: q_wdata.kind = dmxlbp_pkg::CMD_TICK;
      dmxlbp_pkg::ACT_OFF:  q_wdata.kind = dmxlbp_pkg::CMD_OFF;
      default: begin
        // unused code: dropped here
        q_wdata.kind = dmxlbp_pkg::CMD_TICK;
        known = 1'b0;
      end
    endcase
  end

  assign q_wr = in_push & ~in_full & known;

endmodule

@@ src/dmxlbp_cmd_fifo.sv @@
module dmxlbp_cmd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  dmxlbp_pkg::cmd_t wdata,
  output logic             full,
  input  logic             rd,
  output dmxlbp_pkg::cmd_t rdata,
  output logic             empty
);

  localparam int AW    = dmxlbp_pkg::CMDQ_AW;
  localparam int DEPTH = 1 << AW;

  dmxlbp_pkg::cmd_t slot_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr) begin
      wp_nxt = wp_r + 1'b1;
    end
    if (rd) begin
      rp_nxt = rp_r + 1'b1;
    end
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wp_r] <= wdata;
    end
  end

endmodule

@@ src/dmxlbp_back.sv @@
module dmxlbp_back #(
  parameter int MAX_CHANNELS = dmxlbp_pkg::MAX_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [dmxlbp_pkg::CFG_DW-1:0] cfg_data,
  input  dmxlbp_pkg::cmd_t              q_rdata,
  input  logic                          q_empty,
  output logic                          q_rd,
  output logic                          busy,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [2:0]                    out_block_opcode,
  output logic [7:0]                    out_data [dmxlbp_pkg::BLOCK_LEVELS],
  output logic                          out_pass_finished
);

  localparam int AW  = $clog2(MAX_CHANNELS);
  localparam int PW  = $clog2(MAX_CHANNELS + 8);          // holds position + 7
  localparam int CW  = (PW > dmxlbp_pkg::CFG_DW) ? PW : dmxlbp_pkg::CFG_DW;
  localparam int IW  = (PW > 9) ? PW : 9;
  localparam int NLV = dmxlbp_pkg::BLOCK_LEVELS;

  dmxlbp_pkg::back_state_t state_r, state_nxt;

  logic [dmxlbp_pkg::CFG_DW-1:0] cc_r;
  logic                          dr_r;

  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          repeat_r, repeat_nxt;
  logic          upd_r, upd_nxt;
  logic          first_r, first_nxt;
  logic [2:0]    rd_cnt_r, rd_cnt_nxt;
  logic [8:0]    set_chan_r, set_chan_nxt;
  logic [14:0]   set_pct_r, set_pct_nxt;
  logic [22:0]   prod_r, prod_nxt;
  logic          cap_en_r, cap_en_nxt;
  logic [2:0]    cap_slot_r, cap_slot_nxt;
  logic          cap_zero_r, cap_zero_nxt;
  logic [7:0]    lv_r [NLV];

  logic          out_empty_r, out_empty_nxt;
  logic          out_load;
  logic [2:0]    out_op_r;
  logic [7:0]    out_d_r [NLV];
  logic          out_pf_r, out_pf_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic [PW-1:0] rd_idx;
  logic [PW-1:0] pos_sum;
  logic [CW-1:0] limit;
  logic [2:0]    rd_last;
  logic [30:0]   scaled;
  logic          chan_ok;

  dmxlbp_ram #(
    .WIDTH(8),
    .DEPTH(MAX_CHANNELS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy      = (state_r == dmxlbp_pkg::BK_CLEAR);
  assign out_empty = out_empty_r;
  assign out_block_opcode  = out_op_r;
  assign out_pass_finished = out_pf_r;
  always_comb begin
    for (int k = 0; k < NLV; k++) begin
      out_data[k] = out_d_r[k];
    end
  end

  assign rd_idx    = pos_r + PW'(rd_cnt_r);
  assign ram_raddr = AW'(rd_idx);
  assign pos_sum   = pos_r + PW'(NLV);
  assign limit     = (CW'(cc_r) > CW'(MAX_CHANNELS)) ? CW'(MAX_CHANNELS) : CW'(cc_r);
  assign rd_last   = first_r ? 3'(dmxlbp_pkg::FIRST_LEVELS - 1) : 3'(NLV - 1);
  assign scaled    = 31'(prod_r[22:8]) * 31'(dmxlbp_pkg::RECIP_100);
  assign chan_ok   = (IW'(set_chan_r) < IW'(MAX_CHANNELS));

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    pos_nxt       = pos_r;
    repeat_nxt    = repeat_r;
    upd_nxt       = upd_r;
    first_nxt     = first_r;
    rd_cnt_nxt    = rd_cnt_r;
    set_chan_nxt  = set_chan_r;
    set_pct_nxt   = set_pct_r;
    prod_nxt      = prod_r;
    cap_en_nxt    = 1'b0;
    cap_slot_nxt  = cap_slot_r;
    cap_zero_nxt  = cap_zero_r;
    out_empty_nxt = out_empty_r | out_pop;
    out_pf_nxt    = out_pf_r;
    out_load      = 1'b0;
    q_rd          = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = clr_cnt_r;
    ram_wdata     = '0;

    unique case (state_r)
      dmxlbp_pkg::BK_CLEAR: begin
        ram_we = 1'b1;
        if (clr_cnt_r == AW'(MAX_CHANNELS - 1)) begin
          state_nxt = dmxlbp_pkg::BK_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end

      dmxlbp_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_rd = 1'b1;
          unique case (q_rdata.kind)
            dmxlbp_pkg::CMD_SET: begin
              set_chan_nxt = q_rdata.chan;
              set_pct_nxt  = q_rdata.pct;
              repeat_nxt   = 1'b1;
              upd_nxt      = 1'b1;
              state_nxt    = dmxlbp_pkg::BK_MUL;
            end
            dmxlbp_pkg::CMD_OFF: begin
              upd_nxt     = 1'b1;
              clr_cnt_nxt = '0;
              state_nxt   = dmxlbp_pkg::BK_CLEAR;
            end
            dmxlbp_pkg::CMD_TICK: begin
              if (upd_r && dr_r) begin
                first_nxt  = (pos_r == '0);
                rd_cnt_nxt = '0;
                state_nxt  = dmxlbp_pkg::BK_RD;
              end
            end
            default: ;
          endcase
        end
      end

      dmxlbp_pkg::BK_MUL: begin
        prod_nxt  = 23'(set_pct_r) * 23'(dmxlbp_pkg::LEVEL_MAX);
        state_nxt = dmxlbp_pkg::BK_SCALE;
      end

      dmxlbp_pkg::BK_SCALE: begin
        ram_we    = chan_ok;
        ram_waddr = AW'(set_chan_r);
        ram_wdata = scaled[dmxlbp_pkg::RECIP_SH +: 8];
        state_nxt = dmxlbp_pkg::BK_IDLE;
      end

      dmxlbp_pkg::BK_RD: begin
        cap_en_nxt   = 1'b1;
        cap_slot_nxt = first_r ? rd_cnt_r + 3'd1 : rd_cnt_r;
        cap_zero_nxt = (rd_idx >= PW'(MAX_CHANNELS));
        if (rd_cnt_r == rd_last) begin
          state_nxt = dmxlbp_pkg::BK_FIN;
        end else begin
          rd_cnt_nxt = rd_cnt_r + 3'd1;
        end
      end

      dmxlbp_pkg::BK_FIN: begin
        // last level lands in lv_r at this edge
        state_nxt = dmxlbp_pkg::BK_EMIT;
      end

      dmxlbp_pkg::BK_EMIT: begin
        if (out_empty_r || out_pop) begin
          out_load      = 1'b1;
          out_empty_nxt = 1'b0;
          out_pf_nxt    = 1'b0;
          if (first_r) begin
            repeat_nxt = 1'b0;
            pos_nxt    = PW'(dmxlbp_pkg::FIRST_LEVELS);
          end else if (CW'(pos_sum) >= limit) begin
            pos_nxt = '0;
            if (!repeat_r) begin
              upd_nxt    = 1'b0;
              out_pf_nxt = 1'b1;
            end
          end else begin
            pos_nxt = pos_sum;
          end
          state_nxt = dmxlbp_pkg::BK_IDLE;
        end
      end

      default: state_nxt = dmxlbp_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dmxlbp_pkg::BK_CLEAR;
      clr_cnt_r   <= '0;
      pos_r       <= '0;
      repeat_r    <= 1'b0;
      upd_r       <= 1'b0;
      first_r     <= 1'b0;
      rd_cnt_r    <= '0;
      cap_en_r    <= 1'b0;
      out_empty_r <= 1'b1;
      cc_r        <= '0;
      dr_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pos_r       <= pos_nxt;
      repeat_r    <= repeat_nxt;
      upd_r       <= upd_nxt;
      first_r     <= first_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      cap_en_r    <= cap_en_nxt;
      out_empty_r <= out_empty_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          dmxlbp_pkg::CFG_CHANNEL_COUNT: cc_r <= cfg_data;
          dmxlbp_pkg::CFG_DEVICE_READY:  dr_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    set_chan_r <= set_chan_nxt;
    set_pct_r  <= set_pct_nxt;
    prod_r     <= prod_nxt;
    cap_slot_r <= cap_slot_nxt;
    cap_zero_r <= cap_zero_nxt;
    out_pf_r   <= out_pf_nxt;
    if (cap_en_r) begin
      lv_r[cap_slot_r] <= cap_zero_r ? 8'd0 : ram_rdata;
    end
    if (out_load) begin
      out_op_r <= first_r ? dmxlbp_pkg::OP_FIRST : dmxlbp_pkg::OP_NEXT;
      out_d_r[0] <= first_r ? dmxlbp_pkg::FIRST_DATA1 : lv_r[0];
      for (int k = 1; k < NLV; k++) begin
        out_d_r[k] <= lv_r[k];
      end
    end
  end

endmodule

@@ src/dmx_level_block_packetizer_core.sv @@
// DMX level block packetizer. Words pushed on the in_ side are set-level,
// timer-tick or all-off commands (action code 3 is dropped); a tick that finds
// updating active and the device ready yields one block word of an opcode and
// 7 bytes on the out_ side (opcode 4 + byte 1 + levels 0..5 for the first
// block of a pass, opcode 2 + next 7 levels after that). A front decoder
// clamps the percent value and posts a command into a two-entry queue; a back
// sequencer executes commands one at a time against a single-port-read level
// memory. A set pops the queue, multiplies by 255, then does the reciprocal
// divide by 100 and store write; a tick that emits reads the store through a
// memory read port that delivers one level per cycle, then waits while a
// previous block is still unpopped. After reset and after every all-off
// command the store is cleared, one entry per cycle, while full stays high;
// configuration writes are taken at any time. Levels read past the store
// are zero.
module dmx_level_block_packetizer_core #(
  parameter int MAX_CHANNELS = dmxlbp_pkg::MAX_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // config write port
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [dmxlbp_pkg::CFG_DW-1:0] cfg_data,
  // command words
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [1:0]                    in_action,
  input  logic [8:0]                    in_channel_index,
  input  logic signed [15:0]            in_percent_value,
  // block words
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [2:0]                    out_block_opcode,
  output logic [7:0]                    out_data_1,
  output logic [7:0]                    out_data_2,
  output logic [7:0]                    out_data_3,
  output logic [7:0]                    out_data_4,
  output logic [7:0]                    out_data_5,
  output logic [7:0]                    out_data_6,
  output logic [7:0]                    out_data_7,
  output logic                          out_pass_finished
);

  logic             q_wr, q_full, q_rd, q_empty, back_busy;
  dmxlbp_pkg::cmd_t q_wdata, q_rdata;
  logic [7:0]       blk_data [dmxlbp_pkg::BLOCK_LEVELS];

  // decode + clamp
  dmxlbp_front u_front (
    .in_push         (in_push),
    .in_full         (in_full),
    .in_action       (in_action),
    .in_channel_index(in_channel_index),
    .in_percent_value(in_percent_value),
    .back_busy       (back_busy),
    .q_full          (q_full),
    .q_wr            (q_wr),
    .q_wdata         (q_wdata)
  );

  // decouples decode from execution
  dmxlbp_cmd_fifo u_cmdq (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (q_wr),
    .wdata(q_wdata),
    .full (q_full),
    .rd   (q_rd),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  // store, pass state, block assembly and output register
  dmxlbp_back #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q_rdata          (q_rdata),
    .q_empty          (q_empty),
    .q_rd             (q_rd),
    .busy             (back_busy),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_block_opcode (out_block_opcode),
    .out_data         (blk_data),
    .out_pass_finished(out_pass_finished)
  );

  assign out_data_1 = blk_data[0];
  assign out_data_2 = blk_data[1];
  assign out_data_3 = blk_data[2];
  assign out_data_4 = blk_data[3];
  assign out_data_5 = blk_data[4];
  assign out_data_6 = blk_data[5];
  assign out_data_7 = blk_data[6];

endmodule

@@ sim/dmx_level_block_packetizer_core_tb.sv @@
module dmx_level_block_packetizer_core_tb;

  localparam int MAX_CH = dmxlbp_pkg::MAX_CHANNELS_DEF;
  // unused action code, must be dropped by the block
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // a running store clear plus two more all-off clears waiting in the queue, with slack
  localparam int SETTLE_CYCLES = 3 * (MAX_CH + 16);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_WORDS = 150;
  localparam int NUM_PHASES = 10;

  // one block word as seen on the out_ side
  typedef struct packed {
    logic [2:0]      opcode;
    logic [1:7][7:0] lvl;
    logic            fin;
  } dmx_block_t;

  // directed rows: predicted, typed "no block", typed block, or a register write
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NO_BLOCK,
    ROW_BLOCK,
    ROW_CONFIG
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [1:0]         act;
    logic [8:0]         ch;
    logic signed [15:0] pct;
    logic [9:0]         cnt;
    logic               rdy;
    dmx_block_t         blk;
  } row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic                          cfg_index = 1'b0;
  logic [dmxlbp_pkg::CFG_DW-1:0] cfg_data = '0;
  logic                          in_push = 1'b0;
  logic                          in_full;
  logic [1:0]                    in_action = '0;
  logic [8:0]                    in_channel_index = '0;
  logic signed [15:0]            in_percent_value = '0;
  logic                          out_empty;
  logic                          out_pop = 1'b0;
  logic [2:0]                    out_block_opcode;
  logic [7:0]                    out_data_1;
  logic [7:0]                    out_data_2;
  logic [7:0]                    out_data_3;
  logic [7:0]                    out_data_4;
  logic [7:0]                    out_data_5;
  logic [7:0]                    out_data_6;
  logic [7:0]                    out_data_7;
  logic                          out_pass_finished;

  dmx_level_block_packetizer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_action        (in_action),
    .in_channel_index (in_channel_index),
    .in_percent_value (in_percent_value),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_block_opcode (out_block_opcode),
    .out_data_1       (out_data_1),
    .out_data_2       (out_data_2),
    .out_data_3       (out_data_3),
    .out_data_4       (out_data_4),
    .out_data_5       (out_data_5),
    .out_data_6       (out_data_6),
    .out_data_7       (out_data_7),
    .out_pass_finished(out_pass_finished)
  );

  // 4-unit clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Level store mirror: our own copy of the block state and its registers.
  // ---------------------------------------------------------------------------
  logic [7:0] level_mirror [0:MAX_CH-1];
  int         send_pos = 0;
  logic       repeat_mark = 1'b0;
  logic       updating = 1'b0;
  logic [9:0] chan_count_reg = '0;
  logic       dev_ready_reg = 1'b0;

  dmx_block_t pending_blocks[$];   // blocks still owed by the block, oldest first
  int         mismatch_cnt = 0;
  int         cycle_cnt = 0;
  int         pop_hold = 0;
  logic       steady_run = 1'b0;   // phase with no idling on either side

  initial begin
    for (int i = 0; i < MAX_CH; i++) level_mirror[i] = 8'd0;
  end

  // clamp to 0..100 percent, then floor(v*255/25600)
  function automatic logic [7:0] scale_percent(input logic signed [15:0] pct);
    int v;
    v = pct;
    if (v < 0) v = 0;
    else if (v > int'(dmxlbp_pkg::PCT_FULL)) v = int'(dmxlbp_pkg::PCT_FULL);
    return 8'((v * int'(dmxlbp_pkg::LEVEL_MAX)) / int'(dmxlbp_pkg::PCT_FULL));
  endfunction

  // reads past the end of the store come back as zero
  function automatic logic [7:0] stored_level(input int idx);
    if (idx >= MAX_CH) return 8'd0;
    return level_mirror[idx];
  endfunction

  // advance the mirror by one accepted word; returns 1 when a block is owed
  function automatic logic predict_block(input logic [1:0] act, input logic [8:0] ch,
                                         input logic signed [15:0] pct,
                                         output dmx_block_t blk);
    int lim;
    blk = '0;
    case (act)
      dmxlbp_pkg::ACT_SET: begin
        if (int'(ch) < MAX_CH) level_mirror[ch] = scale_percent(pct);
        repeat_mark = 1'b1;
        updating = 1'b1;
        return 1'b0;
      end
      dmxlbp_pkg::ACT_OFF: begin
        // position kept on purpose: a pass in flight carries on
        for (int i = 0; i < MAX_CH; i++) level_mirror[i] = 8'd0;
        updating = 1'b1;
        return 1'b0;
      end
      dmxlbp_pkg::ACT_TICK: begin
        if (!updating || !dev_ready_reg) return 1'b0;
        if (send_pos == 0) begin
          repeat_mark = 1'b0;
          blk.opcode = dmxlbp_pkg::OP_FIRST;
          blk.lvl[1] = dmxlbp_pkg::FIRST_DATA1;
          for (int i = 0; i < dmxlbp_pkg::FIRST_LEVELS; i++) blk.lvl[2+i] = stored_level(i);
          send_pos = dmxlbp_pkg::FIRST_LEVELS;
          return 1'b1;
        end
        blk.opcode = dmxlbp_pkg::OP_NEXT;
        for (int i = 0; i < dmxlbp_pkg::BLOCK_LEVELS; i++)
          blk.lvl[1+i] = stored_level(send_pos + i);
        send_pos += dmxlbp_pkg::BLOCK_LEVELS;
        // counts above the store size behave as the store size
        lim = (int'(chan_count_reg) > MAX_CH) ? MAX_CH : int'(chan_count_reg);
        if (send_pos >= lim) begin
          send_pos = 0;
          if (!repeat_mark) begin
            updating = 1'b0;
            blk.fin = 1'b1;
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // mostly back-to-back, some short gaps, a few long ones; always back-to-back in a steady run
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_run) return 0;
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random pop, compare each popped word with the oldest owed one.
  // Values read right after the edge are the ones the edge sampled.
  // ---------------------------------------------------------------------------
  task automatic check_block();
    dmx_block_t got;
    dmx_block_t want;
    got = {out_block_opcode, out_data_1, out_data_2, out_data_3, out_data_4,
           out_data_5, out_data_6, out_data_7, out_pass_finished};
    if (pending_blocks.size() == 0) begin
      $display("%0t: unexpected block word, expected none, actual %h", $time, got);
      mismatch_cnt++;
      return;
    end
    want = pending_blocks.pop_front();
    if (got.opcode !== want.opcode) begin
      $display("%0t: block_opcode expected %0d actual %0d", $time, want.opcode, got.opcode);
      mismatch_cnt++;
    end
    for (int i = 1; i <= 7; i++) begin
      if (got.lvl[i] !== want.lvl[i]) begin
        $display("%0t: data_%0d expected %0d actual %0d", $time, i, want.lvl[i], got.lvl[i]);
        mismatch_cnt++;
      end
    end
    if (got.fin !== want.fin) begin
      $display("%0t: pass_finished expected %0d actual %0d", $time, want.fin, got.fin);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) check_block();
    if (pop_hold > 0) begin
      out_pop <= 1'b0;
      pop_hold--;
    end else begin
      out_pop <= 1'b1;
      pop_hold = pick_gap();
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Command side.
  // push stays high across back-to-back words; it only drops for a gap or while blocks are drained.
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [1:0] act, input logic [8:0] ch,
                           input logic signed [15:0] pct);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push          <= 1'b1;
    in_action        <= act;
    in_channel_index <= ch;
    in_percent_value <= pct;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // hold off the sender until every owed block has been popped
  task automatic drain_blocks();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_blocks.size() != 0) @(posedge clk);
  endtask

  // registers only change with the block idle: drain, let clears finish, write
  task automatic apply_config(input logic [9:0] cnt, input logic rdy);
    drain_blocks();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= dmxlbp_pkg::CFG_CHANNEL_COUNT;
    cfg_data  <= cnt;
    @(posedge clk);
    cfg_index <= dmxlbp_pkg::CFG_DEVICE_READY;
    cfg_data  <= dmxlbp_pkg::CFG_DW'(rdy);
    @(posedge clk);
    cfg_we <= 1'b0;
    chan_count_reg = cnt;
    dev_ready_reg  = rdy;
  endtask

  function automatic row_t row_word(input row_kind_t kind, input logic [1:0] act,
                                    input logic [8:0] ch, input logic signed [15:0] pct,
                                    input dmx_block_t blk);
    row_t r;
    r = '0;
    r.kind = kind;
    r.act  = act;
    r.ch   = ch;
    r.pct  = pct;
    r.blk  = blk;
    return r;
  endfunction

  function automatic row_t row_cfg(input logic [9:0] cnt, input logic rdy);
    row_t r;
    r = '0;
    r.kind = ROW_CONFIG;
    r.cnt  = cnt;
    r.rdy  = rdy;
    return r;
  endfunction

  initial begin
    row_t               dir_rows[$];
    row_t               row;
    dmx_block_t         blk;
    dmx_block_t         first_blk;
    logic               owed;
    logic [1:0]         act;
    logic [8:0]         ch;
    logic signed [15:0] pct;
    logic [9:0]         cnt;
    logic               rdy;
    int                 r;
    int                 n;
    logic signed [15:0] pct_edges [8];

    pct_edges = '{16'sd0, 16'sd1, 16'sd25599, 16'sd25600, 16'sd25601,
                  -16'sd1, 16'sd32767, -16'sd32768};

    // levels 0..5 after the first set group: 100%, clamped max, 50%, 0, 1%, clamped min
    first_blk = '{dmxlbp_pkg::OP_FIRST,
                  {dmxlbp_pkg::FIRST_DATA1, 8'd255, 8'd255, 8'd127, 8'd0, 8'd2, 8'd0},
                  1'b0};

    // count 0: a pass is just the first block and one later block
    dir_rows.push_back(row_cfg(10'd0, 1'b1));
    // idle tick
    dir_rows.push_back(row_word(ROW_NO_BLOCK, dmxlbp_pkg::ACT_TICK, 9'd0, 16'sd0, '0));
    dir_rows.push_back(row_word(ROW_NO_BLOCK, dmxlbp_pkg::ACT_SET, 9'd0, 16'sd25600, '0));
    dir_rows.push_back(row_word(ROW_NO_BLOCK, dmxlbp_pkg::ACT_SET, 9'd1, 16'sd32767, '0));
    dir_rows.push_back(row_word(ROW_NO_BLOCK, dmxlbp_pkg::ACT_SET, 9'd2, 16'sd12800, '0));
    dir_rows.push_back(row_word(ROW_NO_BLOCK, dmxlbp_pkg::ACT_SET, 9'd5, -16'sd32768, '0));
    dir_rows.push_back(row_word(ROW_NO_BLOCK, dmxlbp_pkg::ACT_SET, 9'd3, -16'sd1, '0));
    dir_rows.push_back(row_word(ROW_NO_BLOCK, dmxlbp_pkg::ACT_SET, 9'd4, 16'sd256, '0));
    dir_rows.push_back(row_word(ROW_BLOCK, dmxlbp_pkg::ACT_TICK, 9'd0, 16'sd0, first_blk));
    dir_rows.push_back(row_word(ROW_BLOCK, dmxlbp_pkg::ACT_TICK, 9'd0, 16'sd0,
                                '{dmxlbp_pkg::OP_NEXT, '0, 1'b1}));
    // stopped
    dir_rows.push_back(row_word(ROW_NO_BLOCK, dmxlbp_pkg::ACT_TICK, 9'd0, 16'sd0, '0));
    // dropped
    dir_rows.push_back(row_word(ROW_NO_BLOCK, ACT_UNUSED, 9'h1FF, -16'sd1, '0));
    // device closed: ticks do nothing
    dir_rows.push_back(row_cfg(10'd0, 1'b0));
    dir_rows.push_back(row_word(ROW_NO_BLOCK, dmxlbp_pkg::ACT_SET, 9'd6, 16'sd25599, '0));
    dir_rows.push_back(row_word(ROW_NO_BLOCK, dmxlbp_pkg::ACT_TICK, 9'd0, 16'sd0, '0));
    // count beyond the store, all bits of the register set
    dir_rows.push_back(row_cfg(10'h3FF, 1'b1));
    dir_rows.push_back(row_word(ROW_BLOCK, dmxlbp_pkg::ACT_TICK, 9'd0, 16'sd0, first_blk));
    dir_rows.push_back(row_word(ROW_NO_BLOCK, dmxlbp_pkg::ACT_SET, 9'd511, 16'sd25600, '0));
    dir_rows.push_back(row_word(ROW_NO_BLOCK, dmxlbp_pkg::ACT_OFF, 9'd0, 16'sd0, '0));
    // all-off mid pass: position is kept, store reads back zero
    dir_rows.push_back(row_word(ROW_PREDICT, dmxlbp_pkg::ACT_TICK, 9'd0, 16'sd0, '0));
    dir_rows.push_back(row_word(ROW_PREDICT, dmxlbp_pkg::ACT_SET, 9'd15, 16'sd100, '0));
    dir_rows.push_back(row_word(ROW_PREDICT, dmxlbp_pkg::ACT_TICK, 9'd0, 16'sd0, '0));
    dir_rows.push_back(row_word(ROW_PREDICT, dmxlbp_pkg::ACT_TICK, 9'd0, 16'sd0, '0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CONFIG) begin
        apply_config(row.cnt, row.rdy);
      end else begin
        push_word(row.act, row.ch, row.pct);
        owed = predict_block(row.act, row.ch, row.pct, blk);
        if (row.kind == ROW_BLOCK) pending_blocks.push_back(row.blk);
        else if (row.kind == ROW_PREDICT && owed) pending_blocks.push_back(blk);
      end
    end

    // random part, one register setting per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin cnt = 10'd512; rdy = 1'b1; end
        1: begin cnt = 10'd7;   rdy = 1'b1; end
        2: begin cnt = 10'h3FF; rdy = 1'b1; end
        3: begin cnt = 10'd0;   rdy = 1'b1; end
        4: begin cnt = 10'd20;  rdy = 1'b0; end
        5: begin cnt = 10'd1;   rdy = 1'b1; end
        default: begin
          cnt = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 60))
                                           : 10'($urandom_range(0, 1023));
          rdy = ($urandom_range(0, 99) < 85);
        end
      endcase
      apply_config(cnt, rdy);
      steady_run = ($urandom_range(0, 3) == 0);
      n = 0;
      while (n < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        if (r < 45) act = dmxlbp_pkg::ACT_SET;
        else if (r < 93) act = dmxlbp_pkg::ACT_TICK;
        else if (r < 96) act = dmxlbp_pkg::ACT_OFF;
        else act = ACT_UNUSED;
        // low channels show up in blocks sooner, so favor them
        ch = ($urandom_range(0, 1) == 0) ? 9'($urandom_range(0, 40))
                                        : 9'($urandom_range(0, 511));
        r = $urandom_range(0, 3);
        if (r == 0) pct = 16'($urandom_range(0, 65535));
        else if (r == 3) pct = pct_edges[$urandom_range(0, 7)];
        else pct = 16'($urandom_range(0, int'(dmxlbp_pkg::PCT_FULL)));
        if ($urandom_range(0, 99) == 0) drain_blocks();
        push_word(act, ch, pct);
        if (predict_block(act, ch, pct, blk)) pending_blocks.push_back(blk);
        if (act != ACT_UNUSED) n++;
      end
    end

    // wind down: everything popped, then room for a trailing clear
    steady_run = 1'b0;
    drain_blocks();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
